@@ hdl/trc_pkg.sv @@
// Shared constants, command and register codes, and LEB128 helpers for the trace ring recorder.
`default_nettype none
package trc_pkg;

  localparam int RING_BYTES_DEF = 1024;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MASK_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STAMP_HZ  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECORDING = 3'd6;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_DRAIN  = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;

  localparam logic [31:0] EV_GAP  = 32'd0;
  localparam logic [31:0] EV_BOOT = 32'd1;

  localparam logic [31:0] STAMP_HZ_RESET = 32'd1000000;

  // Number of LEB128 bytes needed for a 32-bit value.
  function automatic logic [2:0] vlen(input logic [31:0] v);
    logic [2:0] n;
    n = 3'd1;
    if (v > 32'd127) n = 3'd2;
    if (v > 32'd16383) n = 3'd3;
    if (v > 32'd2097151) n = 3'd4;
    if (v > 32'd268435455) n = 3'd5;
    return n;
  endfunction

  // Size of a whole record whose payload is pay bytes long.
  function automatic logic [6:0] rec_size(input logic [5:0] pay);
    return 7'(pay) + 7'(vlen(32'(pay)));
  endfunction

endpackage
`default_nettype wire

@@ hdl/trc_chan_if.sv @@
// Valid/ready channel interfaces for recorder commands and recorder results.
`default_nettype none
interface trc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] trace_id;
  logic [31:0] stamp;
  logic [1:0]  param_count;
  logic [31:0] param_a;
  logic [31:0] param_b;
  logic [31:0] param_c;

  modport source (output valid, cmd, trace_id, stamp, param_count, param_a, param_b,
                  param_c, input ready);
  modport sink (input valid, cmd, trace_id, stamp, param_count, param_a, param_b,
                param_c, output ready);
endinterface

interface trc_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [7:0]  out_byte;
  logic [9:0]  fill_level;
  logic [31:0] dropped_events;
  logic        started;

  modport source (output valid, accepted, out_byte, fill_level, dropped_events, started,
                  input ready);
  modport sink (input valid, accepted, out_byte, fill_level, dropped_events, started,
                output ready);
endinterface
`default_nettype wire

@@ hdl/trc_ring_mem.sv @@
// Byte ring storage: one write port and one registered read port.
`default_nettype none
module trc_ring_mem
  import trc_pkg::*;
#(
  parameter int DEPTH = RING_BYTES_DEF,
  parameter int AW    = $clog2(RING_BYTES_DEF)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ hdl/leb128_trace_ring_recorder.sv @@
// Top level of the LEB128 trace ring recorder: control sequencer, registers and ring.
// An ignored command goes straight to the result; a drain reads one byte from a non-empty ring,
// and a recorded event or start first writes each of its LEB128 bytes to the ring.
// An overrun in overwrite mode first walks the stored records by their length-prefix bytes.
// One command is handled at a time; the next is taken in the cycle after the result is
// registered; a result waits while an earlier one is held. RING_BYTES must be a power of two.
// Synchronous reset clears the indices, counters and flags; ring contents stay undefined.
`default_nettype none
module leb128_trace_ring_recorder
  import trc_pkg::*;
#(
  parameter int RING_BYTES = RING_BYTES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  trc_in_if.sink                     item,
  trc_out_if.source                  result,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(RING_BYTES);
  localparam int CW = (AW + 1 > 8) ? AW + 1 : 8;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CALC = 4'd1;
  localparam logic [3:0] ST_WRD  = 4'd2;
  localparam logic [3:0] ST_WDT  = 4'd3;
  localparam logic [3:0] ST_OVR  = 4'd4;
  localparam logic [3:0] ST_LOAD = 4'd5;
  localparam logic [3:0] ST_EMIT = 4'd6;
  localparam logic [3:0] ST_DRD  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  localparam logic [3:0] SLOT_BOOT_LEN  = 4'd0;
  localparam logic [3:0] SLOT_BOOT_ID   = 4'd1;
  localparam logic [3:0] SLOT_BOOT_TS   = 4'd2;
  localparam logic [3:0] SLOT_BOOT_RATE = 4'd3;
  localparam logic [3:0] SLOT_GAP_LEN   = 4'd4;
  localparam logic [3:0] SLOT_GAP_ID    = 4'd5;
  localparam logic [3:0] SLOT_GAP_DELTA = 4'd6;
  localparam logic [3:0] SLOT_GAP_LOST  = 4'd7;
  localparam logic [3:0] SLOT_EV_LEN    = 4'd8;
  localparam logic [3:0] SLOT_EV_ID     = 4'd9;
  localparam logic [3:0] SLOT_EV_DELTA  = 4'd10;
  localparam logic [3:0] SLOT_PARAM_A   = 4'd11;
  localparam logic [3:0] SLOT_PARAM_B   = 4'd12;
  localparam logic [3:0] SLOT_PARAM_C   = 4'd13;
  localparam logic [3:0] SLOT_LAST      = 4'd13;

  localparam logic [13:0] EN_BOOT  = 14'h000F;
  localparam logic [13:0] EN_GAP   = 14'h00F0;
  localparam logic [13:0] EN_EVENT = 14'h0700;

  logic [63:0] mask [4];
  logic [31:0] rate;
  logic        ovw;
  logic        rec_on;

  logic [3:0]  state;
  logic [1:0]  cmd_q;
  logic [31:0] id_q;
  logic [31:0] ts_q;
  logic [1:0]  np_q;
  logic [31:0] pa_q;
  logic [31:0] pb_q;
  logic [31:0] pc_q;

  logic [AW-1:0] widx;
  logic [AW-1:0] ridx;
  logic [31:0]   lost;
  logic          gap_pend;
  logic [31:0]   last_stamp;
  logic          started;

  logic        acc_q;
  logic [7:0]  ob_q;
  logic [3:0]  slot;
  logic [13:0] slot_en;
  logic [31:0] v;
  logic [5:0]  boot_len;
  logic [5:0]  gap_len;
  logic [5:0]  ev_len;
  logic [31:0] gap_delta;
  logic [31:0] gap_lost;
  logic [31:0] ev_delta;
  logic [4:0]  extra;

  logic [AW-1:0] pos;
  logic [33:0]   walked;
  logic [2:0]    pre;
  logic [31:0]   rlen;
  logic [31:0]   count;

  logic          out_valid;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic [31:0]   delta;
  logic [AW-1:0] held;
  logic [CW-1:0] free_w;
  logic [2:0]    vid;
  logic [2:0]    vd;
  logic [4:0]    extra_c;
  logic [5:0]    gp_pay;
  logic [6:0]    gap_sz;
  logic [5:0]    ev_pay;
  logic [6:0]    need;
  logic          id_en;
  logic [5:0]    bt_pay;
  logic [31:0]   total;
  logic [5:0]    tg_pay;
  logic [5:0]    ow_evp;
  logic [CW-1:0] ow_sum;
  logic [31:0]   slot_val;
  logic [31:0]   v_rest;
  logic [31:0]   rlen_next;
  logic [2:0]    pre_next;
  logic [AW-1:0] pos_inc;

  trc_ring_mem #(
    .DEPTH (RING_BYTES),
    .AW    (AW)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (widx),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        mask[i] <= '1;
      end
      rate   <= STAMP_HZ_RESET;
      ovw    <= 1'b0;
      rec_on <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MASK_0:    mask[0] <= cfg_data;
        REG_MASK_1:    mask[1] <= cfg_data;
        REG_MASK_2:    mask[2] <= cfg_data;
        REG_MASK_3:    mask[3] <= cfg_data;
        REG_STAMP_HZ:  rate    <= cfg_data[31:0];
        REG_OVERWRITE: ovw     <= cfg_data[0];
        REG_RECORDING: rec_on  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign item.ready = (state == ST_IDLE) && !rst;

  always_comb begin
    delta   = ts_q - last_stamp;
    held    = widx - ridx;
    free_w  = CW'(RING_BYTES - 1) - CW'(held);
    vid     = vlen(id_q);
    vd      = vlen(delta);
    extra_c = 5'd0;
    if (np_q >= 2'd1) extra_c = extra_c + 5'(vlen(pa_q));
    if (np_q >= 2'd2) extra_c = extra_c + 5'(vlen(pb_q));
    if (np_q == 2'd3) extra_c = extra_c + 5'(vlen(pc_q));
    gp_pay  = 6'd1 + 6'(vd) + 6'(vlen(lost));
    gap_sz  = gap_pend ? rec_size(gp_pay) : 7'd0;
    ev_pay  = 6'(vid) + 6'(vd) + 6'(extra_c);
    need    = gap_sz + rec_size(ev_pay);
    id_en   = (id_q[31:8] != 24'd0) ? 1'b1 : mask[id_q[7:6]][id_q[5:0]];
    bt_pay  = 6'd1 + 6'(vlen(ts_q)) + 6'(vlen(rate));
    total   = lost + count;
    tg_pay  = 6'd2 + 6'(vlen(total));
    ow_evp  = 6'(vid) + 6'd1 + 6'(extra);
    ow_sum  = CW'(rec_size(bt_pay)) + CW'(rec_size(tg_pay)) + CW'(rec_size(ow_evp));
  end

  always_comb begin
    case (slot)
      SLOT_BOOT_LEN:  slot_val = 32'(boot_len);
      SLOT_BOOT_ID:   slot_val = EV_BOOT;
      SLOT_BOOT_TS:   slot_val = ts_q;
      SLOT_BOOT_RATE: slot_val = rate;
      SLOT_GAP_LEN:   slot_val = 32'(gap_len);
      SLOT_GAP_ID:    slot_val = EV_GAP;
      SLOT_GAP_DELTA: slot_val = gap_delta;
      SLOT_GAP_LOST:  slot_val = gap_lost;
      SLOT_EV_LEN:    slot_val = 32'(ev_len);
      SLOT_EV_ID:     slot_val = id_q;
      SLOT_EV_DELTA:  slot_val = ev_delta;
      SLOT_PARAM_A:   slot_val = pa_q;
      SLOT_PARAM_B:   slot_val = pb_q;
      SLOT_PARAM_C:   slot_val = pc_q;
      default:        slot_val = 32'd0;
    endcase
  end

  assign v_rest    = v >> 7;
  assign mem_we    = (state == ST_EMIT);
  assign mem_wdata = {(v_rest != 32'd0), v[6:0]};
  assign mem_raddr = (state == ST_WRD) ? pos : ridx;
  assign rlen_next = rlen | (32'(mem_rdata[6:0]) << (5'(pre) * 5'd7));
  assign pre_next  = pre + 3'd1;
  assign pos_inc   = pos + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      widx       <= '0;
      ridx       <= '0;
      lost       <= '0;
      gap_pend   <= 1'b0;
      last_stamp <= '0;
      started    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (result.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item.valid) begin
            cmd_q <= item.cmd;
            id_q  <= item.trace_id;
            ts_q  <= item.stamp;
            np_q  <= item.param_count;
            pa_q  <= item.param_a;
            pb_q  <= item.param_b;
            pc_q  <= item.param_c;
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          ob_q    <= 8'd0;
          slot    <= SLOT_BOOT_LEN;
          extra   <= extra_c;
          pos     <= ridx;
          walked  <= '0;
          pre     <= '0;
          rlen    <= '0;
          count   <= '0;
          unique case (cmd_q)
            CMD_RECORD: begin
              if (!(started && rec_on && id_en)) begin
                acc_q <= 1'b0;
                state <= ST_DONE;
              end else if (free_w < CW'(need)) begin
                acc_q <= 1'b0;
                if (ovw) begin
                  state <= ST_WRD;
                end else begin
                  lost     <= lost + 32'd1;
                  gap_pend <= 1'b1;
                  state    <= ST_DONE;
                end
              end else begin
                gap_len   <= gp_pay;
                gap_delta <= delta;
                gap_lost  <= lost;
                ev_delta  <= gap_pend ? 32'd0 : delta;
                ev_len    <= gap_pend ? (6'(vid) + 6'd1 + 6'(extra_c)) : ev_pay;
                slot_en   <= (gap_pend ? EN_GAP : 14'd0) | EN_EVENT
                             | {(np_q == 2'd3), (np_q >= 2'd2), (np_q >= 2'd1), 11'd0};
                lost       <= '0;
                gap_pend   <= 1'b0;
                last_stamp <= ts_q;
                acc_q      <= 1'b1;
                state      <= ST_LOAD;
              end
            end
            CMD_DRAIN: begin
              acc_q <= 1'b0;
              state <= (ridx != widx) ? ST_DRD : ST_DONE;
            end
            CMD_START: begin
              widx       <= '0;
              ridx       <= '0;
              gap_pend   <= 1'b0;
              last_stamp <= ts_q;
              started    <= 1'b1;
              acc_q      <= 1'b0;
              if (rec_on && CW'(RING_BYTES - 1) >= CW'(rec_size(bt_pay))) begin
                lost     <= '0;
                boot_len <= bt_pay;
                slot_en  <= EN_BOOT;
                state    <= ST_LOAD;
              end else begin
                lost  <= rec_on ? 32'd1 : 32'd0;
                state <= ST_DONE;
              end
            end
            default: begin
              acc_q <= 1'b0;
              state <= ST_DONE;
            end
          endcase
        end
        ST_WRD: begin
          if (pre == 3'd0 && (pos == widx || walked >= 34'(RING_BYTES))) begin
            state <= ST_OVR;
          end else begin
            state <= ST_WDT;
          end
        end
        ST_WDT: begin
          if (mem_rdata[7] && pre_next < 3'd5) begin
            pos  <= pos_inc;
            pre  <= pre_next;
            rlen <= rlen_next;
          end else begin
            pos    <= pos_inc + rlen_next[AW-1:0];
            walked <= walked + 34'(pre_next) + 34'(rlen_next);
            count  <= count + 32'd1;
            pre    <= '0;
            rlen   <= '0;
          end
          state <= ST_WRD;
        end
        ST_OVR: begin
          if (ow_sum < CW'(RING_BYTES)) begin
            ridx       <= widx;
            boot_len   <= bt_pay;
            gap_len    <= tg_pay;
            gap_delta  <= 32'd0;
            gap_lost   <= total;
            ev_len     <= ow_evp;
            ev_delta   <= 32'd0;
            slot_en    <= EN_BOOT | EN_GAP | EN_EVENT
                          | {(np_q == 2'd3), (np_q >= 2'd2), (np_q >= 2'd1), 11'd0};
            lost       <= '0;
            gap_pend   <= 1'b0;
            last_stamp <= ts_q;
            acc_q      <= 1'b1;
            state      <= ST_LOAD;
          end else begin
            lost     <= lost + 32'd1;
            gap_pend <= 1'b1;
            state    <= ST_DONE;
          end
        end
        ST_LOAD: begin
          if (slot > SLOT_LAST) begin
            state <= ST_DONE;
          end else if (slot_en[slot]) begin
            v     <= slot_val;
            state <= ST_EMIT;
          end else begin
            slot <= slot + 4'd1;
          end
        end
        ST_EMIT: begin
          widx <= widx + AW'(1);
          v    <= v_rest;
          if (v_rest == 32'd0) begin
            slot  <= slot + 4'd1;
            state <= ST_LOAD;
          end
        end
        ST_DRD: begin
          ob_q  <= mem_rdata;
          acc_q <= 1'b1;
          ridx  <= ridx + AW'(1);
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid             <= 1'b1;
            result.accepted       <= acc_q;
            result.out_byte       <= ob_q;
            result.fill_level     <= 10'(held);
            result.dropped_events <= lost;
            result.started        <= started;
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid = out_valid;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("Recorder took a second transaction while busy.");

  a_byte_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.accepted) |-> (result.out_byte == 8'd0))
    else $error("Non-accepted result carries a byte.");

  a_write_needs_start: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> started)
    else $error("Ring written before the recorder was started.");

endmodule
`default_nettype wire
